// File: src/motion_alarm_kalman_fsm_top_assert.svh
// Assertion macros shared by the checker of the motion alarm block.
`ifndef MOTION_ALARM_KALMAN_FSM_TOP_ASSERT_SVH
`define MOTION_ALARM_KALMAN_FSM_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MAKF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MAKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/makf_pkg.sv
// Package of the motion alarm block: widths, codes and transaction types.
`default_nettype none

package makf_pkg;

	localparam int MAG_WIDTH     = 16;
	localparam int TICK_WIDTH    = 16;
	localparam int CFG_WIDTH     = 16;
	localparam int NOISE_WIDTH   = 15;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int STATE_WIDTH   = 3;
	localparam int COUNT_WIDTH   = 16;

	// Q1.15 gain and variance
	localparam int GAIN_WIDTH    = 16;
	localparam int VAR_WIDTH     = 16;
	localparam int DIV_CNT_WIDTH = $clog2(GAIN_WIDTH);
	localparam int FRAC_BITS     = 15;

	// Common width for magnitude compares and the multiplier's second operand
	localparam int WIDE_WIDTH  = (MAG_WIDTH > CFG_WIDTH) ? MAG_WIDTH : CFG_WIDTH;
	localparam int TCMP_WIDTH  = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;
	localparam int PROD_WIDTH  = GAIN_WIDTH + WIDE_WIDTH;

	localparam logic [GAIN_WIDTH-1:0] ONE_Q15  = GAIN_WIDTH'(1 << FRAC_BITS);
	localparam logic [VAR_WIDTH-1:0]  VAR_INIT = VAR_WIDTH'(1 << FRAC_BITS);
	localparam logic [PROD_WIDTH:0]   ROUND_HALF = (PROD_WIDTH + 1)'(1 << (FRAC_BITS - 1));

	typedef enum logic [STATE_WIDTH-1:0] {
		ST_DISARMED  = 3'd0,
		ST_ARMED     = 3'd1,
		ST_PRE_ALARM = 3'd2,
		ST_ALARM     = 3'd3,
		ST_RIDE      = 3'd4
	} alarm_state_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_PRED,
		SEQ_DIV,
		SEQ_MUL_GAIN,
		SEQ_MUL_VAR,
		SEQ_DECIDE,
		SEQ_OUT
	} seq_state_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_THR_LO      = 3'd0,
		CFG_THR_HI      = 3'd1,
		CFG_ARM_DELAY   = 3'd2,
		CFG_PRE_TIMEOUT = 3'd3,
		CFG_PROC_NOISE  = 3'd4,
		CFG_MEAS_NOISE  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                   mode;
		logic                   sample_present;
		logic [MAG_WIDTH-1:0]   magnitude;
		logic [STATE_WIDTH-1:0] commanded_state;
	} in_item_t;

	typedef struct packed {
		logic [STATE_WIDTH-1:0] machine_state;
		logic [MAG_WIDTH-1:0]   filtered_magnitude;
		logic [COUNT_WIDTH-1:0] alarm_total;
		logic                   state_changed;
	} out_item_t;

endpackage

`default_nettype wire

// File: src/motion_alarm_kalman_fsm_top.sv
// Motion alarm: scalar Kalman smoothing and a five-state alarm machine.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | in_data  (in_item_t)
//   out     | output    | out_valid / out_stall  | out_data (out_item_t)
//   cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// Host command or tick without sample: SEQ_IDLE goes to SEQ_OUT, where the result loads.
// Tick with sample: SEQ_PRED, SEQ_DIV (not for a zero denominator), SEQ_MUL_GAIN, SEQ_MUL_VAR,
// SEQ_DECIDE and SEQ_OUT; the 16-step radix-2 gain divider feeds one shared 16 x 16 multiplier.
// One transaction at a time: in_stall is high from accept until the result loads.
// A stalled result holds in the output register; the next input is taken meanwhile.
// arst_n restores the register defaults, DISARMED, and a cleared filter.
`default_nettype none

module motion_alarm_kalman_fsm_top
	import makf_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire in_item_t                 in_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output out_item_t                     out_data,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

	seq_state_t seq_q, seq_d;

	// configuration
	logic [CFG_WIDTH-1:0]   thr_lo_q, thr_hi_q, arm_delay_q, pre_timeout_q;
	logic [NOISE_WIDTH-1:0] proc_noise_q, meas_noise_q;

	// architectural state
	alarm_state_t           mst_q, before_q;
	logic [MAG_WIDTH-1:0]   est_q;
	logic [VAR_WIDTH-1:0]   var_q;
	logic [TICK_WIDTH-1:0]  tsa_q, tsp_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// working registers of the filter
	logic [MAG_WIDTH-1:0]     z_q;
	logic [VAR_WIDTH-1:0]     ppred_q;
	logic [VAR_WIDTH:0]       den_q;
	logic [VAR_WIDTH+1:0]     rem_q;
	logic [GAIN_WIDTH-1:0]    k_q;
	logic [DIV_CNT_WIDTH-1:0] bit_q;
	logic                     dir_q;
	logic [PROD_WIDTH-1:0]    prod_q;

	out_item_t out_q;
	logic      out_valid_q;

	logic                   accept, out_load;
	logic [VAR_WIDTH:0]     ppred_sum, den_sum;
	logic                   div_ge;
	logic [VAR_WIDTH+1:0]   div_rem;
	logic                   diff_up;
	logic [MAG_WIDTH-1:0]   diff;
	logic [GAIN_WIDTH-1:0]  mul_a;
	logic [WIDE_WIDTH-1:0]  mul_b;
	logic [PROD_WIDTH:0]    rnd;
	logic [MAG_WIDTH-1:0]   step;
	logic [VAR_WIDTH-1:0]   var_new;
	logic [TICK_WIDTH-1:0]  tsa_inc, tsp_inc;
	logic                   est_gt_hi, est_gt_lo, arm_done, pre_expired;
	logic                   enter_en, enter_mach;
	alarm_state_t           enter_tgt;
	logic                   arm_entry;

	// datapath logic
	assign ppred_sum = {1'b0, var_q} + (VAR_WIDTH + 1)'(proc_noise_q);
	assign den_sum   = {1'b0, ppred_sum[VAR_WIDTH-1:0]} + (VAR_WIDTH + 1)'(meas_noise_q);
	assign div_ge    = rem_q >= {1'b0, den_q};
	assign div_rem   = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;
	assign diff_up   = z_q >= est_q;
	assign diff      = diff_up ? (z_q - est_q) : (est_q - z_q);
	assign rnd       = {1'b0, prod_q} + ROUND_HALF;
	assign step      = rnd[FRAC_BITS +: MAG_WIDTH];
	assign var_new   = rnd[FRAC_BITS +: VAR_WIDTH];
	assign tsa_inc   = (&tsa_q) ? tsa_q : tsa_q + 1'b1;
	assign tsp_inc   = (&tsp_q) ? tsp_q : tsp_q + 1'b1;

	assign est_gt_hi   = WIDE_WIDTH'(est_q) > WIDE_WIDTH'(thr_hi_q);
	assign est_gt_lo   = WIDE_WIDTH'(est_q) > WIDE_WIDTH'(thr_lo_q);
	assign arm_done    = TCMP_WIDTH'(tsa_q) >= TCMP_WIDTH'(arm_delay_q);
	assign pre_expired = TCMP_WIDTH'(tsp_q) > TCMP_WIDTH'(pre_timeout_q);
	assign arm_entry   = enter_en && (enter_tgt != mst_q) && (enter_tgt == ST_ARMED);

	// shared multiplier operands: gain times distance, then (1 - gain) times p_pred
	always_comb begin
		if (seq_q == SEQ_MUL_GAIN) begin
			mul_a = k_q;
			mul_b = WIDE_WIDTH'(diff);
		end else begin
			mul_a = GAIN_WIDTH'({1'b0, ONE_Q15} - {1'b0, k_q});
			mul_b = WIDE_WIDTH'(ppred_q);
		end
	end

	assign accept   = in_valid && (seq_q == SEQ_IDLE);
	assign in_stall = (seq_q != SEQ_IDLE);
	assign out_load = (seq_q == SEQ_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	// sequencer and state entry requests
	always_comb begin
		seq_d      = seq_q;
		enter_en   = 1'b0;
		enter_mach = 1'b0;
		enter_tgt  = mst_q;
		unique case (seq_q)
			SEQ_IDLE: begin
				if (accept) begin
					if (in_data.mode || !in_data.sample_present) begin
						seq_d = SEQ_OUT;
					end else begin
						seq_d = SEQ_PRED;
					end
					// drop unused command codes
					if (in_data.mode && (in_data.commanded_state <= STATE_WIDTH'(ST_RIDE))) begin
						enter_en  = 1'b1;
						enter_tgt = alarm_state_t'(in_data.commanded_state);
					end
				end
			end
			SEQ_PRED: begin
				seq_d = (den_sum == '0) ? SEQ_MUL_GAIN : SEQ_DIV;
			end
			SEQ_DIV: begin
				if (bit_q == '0) begin
					seq_d = SEQ_MUL_GAIN;
				end
			end
			SEQ_MUL_GAIN: seq_d = SEQ_MUL_VAR;
			SEQ_MUL_VAR:  seq_d = SEQ_DECIDE;
			SEQ_DECIDE: begin
				seq_d      = SEQ_OUT;
				enter_mach = 1'b1;
				priority if (mst_q == ST_ARMED && arm_done && est_gt_hi) begin
					enter_en  = 1'b1;
					enter_tgt = ST_ALARM;
				end else if (mst_q == ST_ARMED && arm_done && est_gt_lo) begin
					enter_en  = 1'b1;
					enter_tgt = ST_PRE_ALARM;
				end else if (mst_q == ST_PRE_ALARM && est_gt_hi) begin
					enter_en  = 1'b1;
					enter_tgt = ST_ALARM;
				end else if (mst_q == ST_PRE_ALARM && pre_expired) begin
					enter_en  = 1'b1;
					enter_tgt = ST_ARMED;
				end
			end
			SEQ_OUT: begin
				if (out_load) begin
					seq_d = SEQ_IDLE;
				end
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_lo_q      <= CFG_WIDTH'(1229);
			thr_hi_q      <= CFG_WIDTH'(3277);
			arm_delay_q   <= CFG_WIDTH'(150);
			pre_timeout_q <= CFG_WIDTH'(500);
			proc_noise_q  <= NOISE_WIDTH'(328);
			meas_noise_q  <= NOISE_WIDTH'(3277);
			mst_q         <= ST_DISARMED;
			est_q         <= '0;
			var_q         <= VAR_INIT;
			tsa_q         <= '0;
			tsp_q         <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_THR_LO:      thr_lo_q      <= cfg_data;
					CFG_THR_HI:      thr_hi_q      <= cfg_data;
					CFG_ARM_DELAY:   arm_delay_q   <= cfg_data;
					CFG_PRE_TIMEOUT: pre_timeout_q <= cfg_data;
					CFG_PROC_NOISE:  proc_noise_q  <= cfg_data[NOISE_WIDTH-1:0];
					CFG_MEAS_NOISE:  meas_noise_q  <= cfg_data[NOISE_WIDTH-1:0];
					default: ;
				endcase
			end

			if (accept && !in_data.mode) begin
				tsa_q <= tsa_inc;
				tsp_q <= tsp_inc;
			end

			if (seq_q == SEQ_MUL_VAR) begin
				est_q <= dir_q ? (est_q + step) : (est_q - step);
			end

			if ((seq_q == SEQ_DECIDE) && !arm_entry) begin
				var_q <= var_new;
			end

			// entry side effects override the updates above
			if (enter_en && (enter_tgt != mst_q)) begin
				mst_q <= enter_tgt;
				unique case (enter_tgt)
					ST_ARMED: begin
						est_q <= '0;
						var_q <= VAR_INIT;
						tsa_q <= '0;
					end
					ST_PRE_ALARM: tsp_q <= '0;
					ST_ALARM: begin
						if (enter_mach) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// filter working registers and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			z_q      <= in_data.magnitude;
			before_q <= mst_q;
		end
		if (seq_q == SEQ_PRED) begin
			ppred_q <= ppred_sum[VAR_WIDTH-1:0];
			den_q   <= den_sum;
			rem_q   <= {2'b00, ppred_sum[VAR_WIDTH-1:0]};
			k_q     <= (den_sum == '0) ? ONE_Q15 : '0;
			bit_q   <= DIV_CNT_WIDTH'(GAIN_WIDTH - 1);
		end
		if (seq_q == SEQ_DIV) begin
			// one quotient bit per cycle; low dividend bits are zero
			k_q   <= {k_q[GAIN_WIDTH-2:0], div_ge};
			rem_q <= {div_rem[VAR_WIDTH:0], 1'b0};
			bit_q <= bit_q - 1'b1;
		end
		if (seq_q == SEQ_MUL_GAIN) begin
			dir_q <= diff_up;
		end
		if (seq_q == SEQ_MUL_GAIN || seq_q == SEQ_MUL_VAR) begin
			prod_q <= PROD_WIDTH'(mul_a * mul_b);
		end
		if (out_load) begin
			out_q.machine_state      <= STATE_WIDTH'(mst_q);
			out_q.filtered_magnitude <= est_q;
			out_q.alarm_total        <= cnt_q;
			out_q.state_changed      <= (mst_q != before_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: src/makf_checker.sv
// Port-level checker of the motion alarm block and its bind.
`default_nettype none

`include "motion_alarm_kalman_fsm_top_assert.svh"

module makf_checker
	import makf_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	// hold a stalled result
	`MAKF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// busy right after each accepted transaction
	`MAKF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after accept")

	// a result appears only at the end of a busy period
	`MAKF_ASSERT_SAME(a_result_after_busy, $rose(out_valid), $past(in_stall), "result without a transaction in flight")

endmodule

bind motion_alarm_kalman_fsm_top makf_checker u_makf_checker (.*);

`default_nettype wire
